### hdl/jsv_pkg.sv
`default_nettype none
package jsv_pkg;

	// Parser modes
	localparam logic [4:0] M_VALUE      = 5'd0;
	localparam logic [4:0] M_OBJ_FIRST  = 5'd1;
	localparam logic [4:0] M_ARR_FIRST  = 5'd2;
	localparam logic [4:0] M_COLON      = 5'd3;
	localparam logic [4:0] M_SEP        = 5'd4;
	localparam logic [4:0] M_END        = 5'd5;
	localparam logic [4:0] M_SLASH      = 5'd6;
	localparam logic [4:0] M_LINE       = 5'd7;
	localparam logic [4:0] M_BLOCK      = 5'd8;
	localparam logic [4:0] M_BLOCK_STAR = 5'd9;
	localparam logic [4:0] M_LIT        = 5'd10;
	localparam logic [4:0] M_N_SIGN     = 5'd11;
	localparam logic [4:0] M_N_ZERO     = 5'd12;
	localparam logic [4:0] M_N_HEX0     = 5'd13;
	localparam logic [4:0] M_N_HEX      = 5'd14;
	localparam logic [4:0] M_N_BIN0     = 5'd15;
	localparam logic [4:0] M_N_BIN      = 5'd16;
	localparam logic [4:0] M_N_INT      = 5'd17;
	localparam logic [4:0] M_N_FRAC0    = 5'd18;
	localparam logic [4:0] M_N_FRAC     = 5'd19;
	localparam logic [4:0] M_N_EXP0     = 5'd20;
	localparam logic [4:0] M_N_EXPS     = 5'd21;
	localparam logic [4:0] M_N_EXP      = 5'd22;
	localparam logic [4:0] M_STR        = 5'd23;
	localparam logic [4:0] M_ESC        = 5'd24;
	localparam logic [4:0] M_HEX        = 5'd25;
	localparam logic [4:0] M_SUR_BS     = 5'd26;
	localparam logic [4:0] M_SUR_U      = 5'd27;
	localparam logic [4:0] M_UTF        = 5'd28;
	localparam logic [4:0] M_ERR        = 5'd29;

	// Escape hex kinds
	localparam logic [1:0] HK_X    = 2'd0;
	localparam logic [1:0] HK_U    = 2'd1;
	localparam logic [1:0] HK_BIGU = 2'd2;
	localparam logic [1:0] HK_LOW  = 2'd3;

	// Status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_OPEN_CMT  = 4'd1;
	localparam logic [3:0] ST_BAD_SLASH = 4'd2;
	localparam logic [3:0] ST_OPEN_STR  = 4'd3;
	localparam logic [3:0] ST_BAD_X     = 4'd4;
	localparam logic [3:0] ST_BAD_U     = 4'd5;
	localparam logic [3:0] ST_BAD_BIGU  = 4'd6;
	localparam logic [3:0] ST_BAD_ESC   = 4'd7;
	localparam logic [3:0] ST_BAD_UTF8  = 4'd8;
	localparam logic [3:0] ST_NO_KEY    = 4'd9;
	localparam logic [3:0] ST_NO_COLON  = 4'd10;
	localparam logic [3:0] ST_NO_COMMA  = 4'd11;
	localparam logic [3:0] ST_NO_VALUE  = 4'd12;
	localparam logic [3:0] ST_TRAILING  = 4'd13;
	localparam logic [3:0] ST_TOO_DEEP  = 4'd14;

	// Mark position update
	localparam logic [1:0] MK_NONE = 2'd0;
	localparam logic [1:0] MK_P    = 2'd1;
	localparam logic [1:0] MK_P1   = 2'd2;

	// Error position source
	localparam logic [1:0] EP_P    = 2'd0;
	localparam logic [1:0] EP_P1   = 2'd1;
	localparam logic [1:0] EP_MARK = 2'd2;
	localparam logic [1:0] EP_TOK  = 2'd3;

	typedef struct packed {
		logic [4:0]  mode;
		logic [2:0]  ret;
		logic [15:0] acc;
		logic [3:0]  dl;
		logic [3:0]  err;
		logic        key;
		logic [1:0]  hk;
	} parse_st_t;

	localparam parse_st_t ST_RESET = '{
		mode: M_VALUE, ret: M_VALUE[2:0], acc: 16'h0, dl: 4'h0,
		err: ST_OK, key: 1'b0, hk: HK_X
	};

	typedef struct packed {
		logic depth_zero;
		logic depth_one;
		logic depth_full;
		logic top_arr;
	} nest_ctx_t;

	typedef struct packed {
		logic push;
		logic push_arr;
		logic pop;
		logic clear;
	} nest_op_t;

	typedef struct packed {
		parse_st_t  st;
		logic       redo;
		logic       inc;
		logic       push;
		logic       push_arr;
		logic       pop;
		logic       tok_set;
		logic [1:0] mark_sel;
		logic       err_set;
		logic [1:0] err_sel;
	} pass_t;

	function automatic logic is_space(logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_hex(logic [7:0] b);
		return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] b);
		logic [7:0] v;
		if (is_digit(b))
			v = b - "0";
		else if (b >= "a" && b <= "f")
			v = b - "a" + 8'd10;
		else
			v = b - "A" + 8'd10;
		return v[3:0];
	endfunction

	function automatic logic is_simple_esc(logic [7:0] b);
		return b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
			b == "n" || b == "r" || b == "t";
	endfunction

	localparam logic [7:0] LIT_TEXT [6][10] = '{
		'{"t", "r", "u", "e", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"f", "a", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"n", "u", "l", "l", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"N", "a", "N", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"I", "n", "f", "i", "n", "i", "t", "y", 8'h0, 8'h0},
		'{"-", "I", "n", "f", "i", "n", "i", "t", "y", 8'h0}
	};

	localparam logic [3:0] LIT_LEN [6] = '{4'd4, 4'd5, 4'd4, 4'd3, 4'd8, 4'd9};

	// One pass of the parser over one byte. A set redo asks for the same
	// byte to be handled again in the new mode.
	function automatic pass_t parse_pass(parse_st_t s, logic [7:0] b, nest_ctx_t c);
		pass_t       r;
		logic [4:0]  m;
		logic [2:0]  id;
		logic [3:0]  li;
		logic [15:0] nacc;
		logic [3:0]  ndl;
		logic [7:0]  lead;
		logic [3:0]  need;
		logic        bad;
		logic [4:0]  after_v;
		logic [4:0]  after_c;
		r = '0;
		r.st = s;
		m = s.mode;
		after_v = c.depth_zero ? M_END : M_SEP;
		after_c = c.depth_one ? M_END : M_SEP;
		id = (s.acc < 16'd6) ? s.acc[2:0] : 3'd0;
		li = (s.dl < 4'd10) ? s.dl : 4'd9;
		nacc = {s.acc[11:0], hex_val(b)};
		ndl = (s.dl != 4'd0) ? s.dl - 4'd1 : 4'd0;
		lead = s.acc[7:0];
		need = (lead[7:4] == 4'hE) ? 4'd2 : (lead[7:3] == 5'b11110) ? 4'd3 : 4'd1;
		bad = b[7:6] != 2'b10;
		if (s.dl == need)
			bad = bad || (lead == 8'hE0 && b < 8'hA0) || (lead == 8'hED && b >= 8'hA0) ||
				(lead == 8'hF0 && b < 8'h90) || (lead == 8'hF4 && b > 8'h8F);

		if (m <= M_END && is_space(b)) begin
			r.st.mode = m;
		end else if (m <= M_END && b == "/") begin
			r.st.ret = m[2:0];
			r.mark_sel = MK_P;
			r.st.mode = M_SLASH;
		end else begin
			unique case (m)
				M_VALUE: begin
					r.tok_set = 1'b1;
					priority if (b == "{" || b == "[") begin
						if (c.depth_full) begin
							r.st.mode = M_ERR; r.st.err = ST_TOO_DEEP; r.err_set = 1'b1;
							r.err_sel = EP_P;
						end else begin
							r.push = 1'b1;
							r.push_arr = (b == "[");
							r.inc = 1'b1;
							r.st.mode = (b == "[") ? M_ARR_FIRST : M_OBJ_FIRST;
						end
					end else if (b == "\"") begin
						r.st.key = 1'b0; r.st.mode = M_STR;
					end else if (b == "t" || b == "f" || b == "n" || b == "N" || b == "I") begin
						r.st.acc = (b == "t") ? 16'd0 : (b == "f") ? 16'd1 :
							(b == "n") ? 16'd2 : (b == "N") ? 16'd3 : 16'd4;
						r.st.dl = 4'd1;
						r.st.mode = M_LIT;
					end else if (b == "-") begin
						r.st.mode = M_N_SIGN;
					end else if (b == "0") begin
						r.st.mode = M_N_ZERO;
					end else if (is_digit(b)) begin
						r.st.mode = M_N_INT;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_P;
					end
				end
				M_OBJ_FIRST: begin
					priority if (b == "}") begin
						r.pop = 1'b1; r.st.mode = after_c;
					end else if (b == "\"") begin
						r.tok_set = 1'b1; r.st.key = 1'b1; r.st.mode = M_STR;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_KEY; r.err_set = 1'b1;
						r.err_sel = EP_P;
					end
				end
				M_ARR_FIRST: begin
					if (b == "]") begin
						r.pop = 1'b1; r.st.mode = after_c;
					end else begin
						r.st.mode = M_VALUE; r.redo = 1'b1;
					end
				end
				M_COLON: begin
					if (b == ":") begin
						r.st.mode = M_VALUE;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_COLON; r.err_set = 1'b1;
						r.err_sel = EP_P;
					end
				end
				M_SEP: begin
					priority if (b == (c.top_arr ? "]" : "}")) begin
						r.pop = 1'b1; r.st.mode = after_c;
					end else if (b == ",") begin
						r.st.mode = c.top_arr ? M_ARR_FIRST : M_OBJ_FIRST;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_COMMA; r.err_set = 1'b1;
						r.err_sel = EP_P;
					end
				end
				M_END: begin
					if (b != 8'h00) begin
						r.st.mode = M_ERR; r.st.err = ST_TRAILING; r.err_set = 1'b1;
						r.err_sel = EP_P;
					end
				end
				M_SLASH: begin
					priority if (b == "/") begin
						r.st.mode = M_LINE;
					end else if (b == "*") begin
						r.mark_sel = MK_P1; r.st.mode = M_BLOCK;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_BAD_SLASH; r.err_set = 1'b1;
						r.err_sel = EP_MARK;
					end
				end
				M_LINE: begin
					if (b == 8'h0A) begin
						r.st.mode = {2'b00, s.ret};
					end else if (b == 8'h00) begin
						r.st.mode = {2'b00, s.ret}; r.redo = 1'b1;
					end
				end
				M_BLOCK, M_BLOCK_STAR: begin
					priority if (b == 8'h00) begin
						r.st.mode = M_ERR; r.st.err = ST_OPEN_CMT; r.err_set = 1'b1;
						r.err_sel = EP_MARK;
					end else if (m == M_BLOCK_STAR && b == "/") begin
						r.st.mode = {2'b00, s.ret};
					end else begin
						r.st.mode = (b == "*") ? M_BLOCK_STAR : M_BLOCK;
					end
				end
				M_LIT: begin
					if (b != LIT_TEXT[id][li]) begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end else begin
						r.st.dl = li + 4'd1;
						if (li + 4'd1 >= LIT_LEN[id])
							r.st.mode = after_v;
					end
				end
				M_N_SIGN: begin
					priority if (b == "0") begin
						r.st.mode = M_N_ZERO;
					end else if (is_digit(b)) begin
						r.st.mode = M_N_INT;
					end else if (b == "I") begin
						r.st.acc = 16'd5; r.st.dl = 4'd2; r.st.mode = M_LIT;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end
				end
				M_N_ZERO: begin
					priority if (b == "x") begin
						r.st.mode = M_N_HEX0;
					end else if (b == "b") begin
						r.st.mode = M_N_BIN0;
					end else if (b == ".") begin
						r.st.mode = M_N_FRAC0;
					end else if (b == "e" || b == "E") begin
						r.st.mode = M_N_EXP0;
					end else if (b == 8'h00 || is_space(b) || b == "," || b == "}" ||
							b == "]") begin
						r.inc = 1'b1; r.st.mode = after_v; r.redo = 1'b1;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end
				end
				M_N_HEX0, M_N_HEX: begin
					priority if (is_hex(b)) begin
						r.st.mode = M_N_HEX;
					end else if (m == M_N_HEX) begin
						r.inc = 1'b1; r.st.mode = after_v; r.redo = 1'b1;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end
				end
				M_N_BIN0, M_N_BIN: begin
					priority if (b == "0" || b == "1") begin
						r.st.mode = M_N_BIN;
					end else if (m == M_N_BIN) begin
						r.inc = 1'b1; r.st.mode = after_v; r.redo = 1'b1;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end
				end
				M_N_INT, M_N_FRAC: begin
					priority if (is_digit(b)) begin
						r.st.mode = m;
					end else if (b == "." && m == M_N_INT) begin
						r.st.mode = M_N_FRAC0;
					end else if (b == "e" || b == "E") begin
						r.st.mode = M_N_EXP0;
					end else begin
						r.inc = 1'b1; r.st.mode = after_v; r.redo = 1'b1;
					end
				end
				M_N_FRAC0, M_N_EXPS: begin
					if (is_digit(b)) begin
						r.st.mode = (m == M_N_FRAC0) ? M_N_FRAC : M_N_EXP;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end
				end
				M_N_EXP0: begin
					priority if (b == "+" || b == "-") begin
						r.st.mode = M_N_EXPS;
					end else if (is_digit(b)) begin
						r.st.mode = M_N_EXP;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_NO_VALUE; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end
				end
				M_N_EXP: begin
					if (!is_digit(b)) begin
						r.inc = 1'b1; r.st.mode = after_v; r.redo = 1'b1;
					end
				end
				M_STR: begin
					priority if (b < 8'h20) begin
						r.st.mode = M_ERR; r.st.err = ST_OPEN_STR; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end else if (b == "\"") begin
						r.inc = 1'b1;
						r.st.mode = s.key ? M_COLON : after_v;
					end else if (b == "\\") begin
						r.st.mode = M_ESC;
					end else if (b < 8'h80) begin
						r.st.mode = M_STR;
					end else if ((b[7:5] == 3'b110 && b >= 8'hC2) || b[7:4] == 4'hE ||
							(b[7:3] == 5'b11110 && b <= 8'hF4)) begin
						r.st.acc = {8'h00, b};
						r.st.dl = (b[7:5] == 3'b110) ? 4'd1 : (b[7:4] == 4'hE) ? 4'd2 : 4'd3;
						r.mark_sel = MK_P;
						r.st.mode = M_UTF;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_BAD_UTF8; r.err_set = 1'b1;
						r.err_sel = EP_P;
					end
				end
				M_ESC: begin
					priority if (b == 8'h00) begin
						r.st.mode = M_ERR; r.st.err = ST_OPEN_STR; r.err_set = 1'b1;
						r.err_sel = EP_TOK;
					end else if (is_simple_esc(b)) begin
						r.st.mode = M_STR;
					end else if (b == "x" || b == "u" || b == "U") begin
						r.st.hk = (b == "x") ? HK_X : (b == "u") ? HK_U : HK_BIGU;
						r.st.dl = (b == "x") ? 4'd2 : (b == "u") ? 4'd4 : 4'd8;
						r.st.acc = 16'h0;
						r.mark_sel = MK_P1;
						r.st.mode = M_HEX;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_BAD_ESC; r.err_set = 1'b1;
						r.err_sel = EP_P1;
					end
				end
				M_HEX: begin
					if (!is_hex(b)) begin
						r.st.mode = M_ERR;
						r.st.err = (s.hk == HK_X) ? ST_BAD_X : (s.hk == HK_BIGU) ?
							ST_BAD_BIGU : ST_BAD_U;
						r.err_set = 1'b1;
						r.err_sel = EP_MARK;
					end else begin
						r.st.acc = nacc;
						r.st.dl = ndl;
						priority if (ndl != 4'd0) begin
							r.st.mode = M_HEX;
						end else if (s.hk == HK_U && nacc >= 16'hD800 && nacc <= 16'hDBFF) begin
							r.mark_sel = MK_P1;
							r.st.mode = M_SUR_BS;
						end else if (s.hk == HK_LOW && (nacc < 16'hDC00 || nacc > 16'hDFFF)) begin
							r.st.mode = M_ERR; r.st.err = ST_BAD_U; r.err_set = 1'b1;
							r.err_sel = EP_MARK;
						end else begin
							r.st.mode = M_STR;
						end
					end
				end
				M_SUR_BS: begin
					if (b == "\\") begin
						r.st.mode = M_SUR_U;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_BAD_U; r.err_set = 1'b1;
						r.err_sel = EP_MARK;
					end
				end
				M_SUR_U: begin
					if (b == "u") begin
						r.st.hk = HK_LOW; r.st.dl = 4'd4; r.st.acc = 16'h0;
						r.mark_sel = MK_P1; r.st.mode = M_HEX;
					end else begin
						r.st.mode = M_ERR; r.st.err = ST_BAD_U; r.err_set = 1'b1;
						r.err_sel = EP_MARK;
					end
				end
				M_UTF: begin
					if (bad) begin
						r.st.mode = M_ERR; r.st.err = ST_BAD_UTF8; r.err_set = 1'b1;
						r.err_sel = EP_MARK;
					end else begin
						r.st.dl = ndl;
						r.st.mode = (ndl == 4'd0) ? M_STR : M_UTF;
					end
				end
				default: begin
					r.st.mode = m;
				end
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/jsv_if.sv
`default_nettype none
interface jsv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

interface jsv_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [31:0] error_position;
	logic [31:0] entry_count;
	modport source(output valid, output status, output error_position, output entry_count,
		input ready);
	modport sink(input valid, input status, input error_position, input entry_count,
		output ready);
endinterface
`default_nettype wire

### hdl/json_syntax_validator_unit.sv
// Result: loaded into the result register once its zero byte has passed the input
//   register and the parser; the sink can then take it.
// Throughput: one byte per cycle; the parser state advances once per byte in one
//   combinational step between the input register and the state/result registers.
// The input side stalls only while a finished result waits on a stalled output.
// Reset (arst_n low, asynchronous): parser returns to expecting a top-level value,
//   counters, positions and nesting depth clear; no clearing pass is needed.
`default_nettype none
module json_syntax_validator_unit #(
	parameter int MAX_DEPTH = 64,
	parameter int POS_WIDTH = 32
) (
	input wire        clk,
	input wire        arst_n,
	jsv_in_if.sink    text_in,
	jsv_out_if.source result_out
);
	import jsv_pkg::*;

	// Input register stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// Result register
	logic        out_vld_q;
	logic [3:0]  status_q;
	logic [31:0] errpos_q;
	logic [31:0] count_q;

	nest_ctx_t   ctx;
	nest_op_t    op;
	logic        done;
	logic [3:0]  status_c;
	logic [31:0] errpos_c;
	logic [31:0] count_c;

	// Hold the byte in stage one only while its result cannot enter the
	// result register; every other byte advances at once.
	assign advance = vld_s1 && !(byte_s1 == 8'h00 && out_vld_q && !result_out.ready);
	assign text_in.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (text_in.ready)
			vld_s1 <= text_in.valid;
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid)
			byte_s1 <= text_in.text_byte;
	end

	jsv_nest_stack #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.ctx    (ctx)
	);

	jsv_parser #(
		.POS_WIDTH(POS_WIDTH)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.text_byte      (byte_s1),
		.ctx            (ctx),
		.op             (op),
		.done           (done),
		.status         (status_c),
		.error_position (errpos_c),
		.entry_count    (count_c)
	);

	// Load a result on the terminator; drop it once the sink takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (done)
			out_vld_q <= 1'b1;
		else if (result_out.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= status_c;
			errpos_q <= errpos_c;
			count_q  <= count_c;
		end
	end

	assign result_out.valid          = out_vld_q;
	assign result_out.status         = status_q;
	assign result_out.error_position = errpos_q;
	assign result_out.entry_count    = count_q;
endmodule
`default_nettype wire

### hdl/jsv_nest_stack.sv
`default_nettype none
module jsv_nest_stack #(
	parameter int MAX_DEPTH = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire jsv_pkg::nest_op_t op,
	output jsv_pkg::nest_ctx_t     ctx
);
	import jsv_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int XW = (DW > AW) ? DW : AW;

	logic          kind_mem [MAX_DEPTH];
	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_d;
	logic          top_q;
	logic          under_q;
	logic [XW-1:0] wr_addr;
	logic [XW-1:0] rd_addr;

	always_comb begin
		priority if (op.clear)
			depth_d = '0;
		else if (op.push)
			depth_d = depth_q + 1'b1;
		else if (op.pop)
			depth_d = depth_q - 1'b1;
		else
			depth_d = depth_q;
	end

	assign wr_addr = XW'(depth_q);
	assign rd_addr = XW'(depth_d) - XW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			depth_q <= '0;
		else
			depth_q <= depth_d;
	end

	// Prefetch the entry under the new top so a pop can restore it at once.
	always_ff @(posedge clk) begin
		if (op.push && !op.clear)
			kind_mem[wr_addr[AW-1:0]] <= op.push_arr;
		under_q <= kind_mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (op.push)
			top_q <= op.push_arr;
		else if (op.pop)
			top_q <= under_q;
	end

	assign ctx.depth_zero = (depth_q == '0);
	assign ctx.depth_one  = (depth_q == DW'(1));
	assign ctx.depth_full = (depth_q >= DW'(MAX_DEPTH));
	assign ctx.top_arr    = top_q;
endmodule
`default_nettype wire

### hdl/jsv_parser.sv
`default_nettype none
module jsv_parser #(
	parameter int POS_WIDTH = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  wire  [7:0]              text_byte,
	input  wire jsv_pkg::nest_ctx_t ctx,
	output jsv_pkg::nest_op_t       op,
	output logic                    done,
	output logic [3:0]              status,
	output logic [31:0]             error_position,
	output logic [31:0]             entry_count
);
	import jsv_pkg::*;

	parse_st_t            st_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] pos_nx;
	logic [POS_WIDTH-1:0] tok_q;
	logic [POS_WIDTH-1:0] mark_q;
	logic [POS_WIDTH-1:0] errpos_q;
	logic [POS_WIDTH-1:0] errpos_d;
	logic [POS_WIDTH-1:0] mark_d;
	logic [POS_WIDTH+31:0] errpos_ext;
	logic [31:0]          cnt_q;
	logic [31:0]          cnt_d;

	pass_t     p1, p2, p3;
	logic      use2, use3;
	parse_st_t st_d;
	logic      inc, push, pop, tok_set, err_set;
	logic      push_arr;
	logic [1:0] mark_sel, err_sel;

	// Up to three chained passes, each taken on a redo: comment end, array head, number end, then the value itself.
	assign p1 = parse_pass(st_q, text_byte, ctx);
	assign p2 = parse_pass(p1.st, text_byte, ctx);
	assign p3 = parse_pass(p2.st, text_byte, ctx);
	assign use2 = p1.redo;
	assign use3 = p1.redo && p2.redo;

	always_comb begin
		st_d = use3 ? p3.st : use2 ? p2.st : p1.st;
		inc = p1.inc | (use2 & p2.inc) | (use3 & p3.inc);
		push = p1.push | (use2 & p2.push) | (use3 & p3.push);
		push_arr = p1.push_arr | (use2 & p2.push_arr) | (use3 & p3.push_arr);
		pop = p1.pop | (use2 & p2.pop) | (use3 & p3.pop);
		tok_set = p1.tok_set | (use2 & p2.tok_set) | (use3 & p3.tok_set);
		priority if (use3 && p3.mark_sel != MK_NONE)
			mark_sel = p3.mark_sel;
		else if (use2 && p2.mark_sel != MK_NONE)
			mark_sel = p2.mark_sel;
		else
			mark_sel = p1.mark_sel;
		priority if (use3 && p3.err_set) begin
			err_set = 1'b1; err_sel = p3.err_sel;
		end else if (use2 && p2.err_set) begin
			err_set = 1'b1; err_sel = p2.err_sel;
		end else begin
			err_set = p1.err_set; err_sel = p1.err_sel;
		end
	end

	assign pos_nx = (pos_q == '1) ? pos_q : pos_q + 1'b1;

	always_comb begin
		unique case (mark_sel)
			MK_P:    mark_d = pos_q;
			MK_P1:   mark_d = pos_nx;
			default: mark_d = mark_q;
		endcase
		if (!err_set)
			errpos_d = errpos_q;
		else begin
			unique case (err_sel)
				EP_P:    errpos_d = pos_q;
				EP_P1:   errpos_d = pos_nx;
				EP_MARK: errpos_d = mark_q;
				default: errpos_d = tok_q;
			endcase
		end
	end

	assign cnt_d = (inc && cnt_q != '1) ? cnt_q + 32'd1 : cnt_q;
	assign done = en && (text_byte == 8'h00);

	assign errpos_ext = {32'h0, errpos_d};
	assign status = st_d.err;
	assign error_position = (st_d.err != ST_OK) ? errpos_ext[31:0] : 32'h0;
	assign entry_count = cnt_d;

	assign op.clear    = done;
	assign op.push     = en && push;
	assign op.push_arr = push_arr;
	assign op.pop      = en && pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_RESET;
			pos_q    <= '0;
			tok_q    <= '0;
			mark_q   <= '0;
			errpos_q <= '0;
			cnt_q    <= '0;
		end else if (done) begin
			st_q     <= ST_RESET;
			pos_q    <= '0;
			tok_q    <= '0;
			mark_q   <= '0;
			errpos_q <= '0;
			cnt_q    <= '0;
		end else if (en) begin
			st_q     <= st_d;
			pos_q    <= pos_nx;
			if (tok_set)
				tok_q <= pos_q;
			mark_q   <= mark_d;
			errpos_q <= errpos_d;
			cnt_q    <= cnt_d;
		end
	end
endmodule
`default_nettype wire

### hdl/jsv_checker.sv
`default_nettype none
module jsv_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire [7:0]  in_byte,
	input wire        out_valid,
	input wire        out_ready,
	input wire [3:0]  out_status,
	input wire [31:0] out_error_position
);
	// A stalled result transaction holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status))
		else $error("result dropped or changed while stalled");

	// Status stays within the defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status <= 4'd14)
		else $error("status out of range");

	// A clean document reports position zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == 4'd0 |-> out_error_position == 32'h0)
		else $error("nonzero position on ok status");

	// A fresh result is preceded by an accepted terminator byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_byte == 8'h00, 2))
		else $error("result without terminator");

	// Input backpressure only comes from a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");
endmodule

bind json_syntax_validator_unit jsv_checker u_jsv_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (text_in.valid),
	.in_ready           (text_in.ready),
	.in_byte            (text_in.text_byte),
	.out_valid          (result_out.valid),
	.out_ready          (result_out.ready),
	.out_status         (result_out.status),
	.out_error_position (result_out.error_position)
);
`default_nettype wire

### sim/json_syntax_validator_unit_tb.sv
`default_nettype none
module json_syntax_validator_unit_tb;
	import jsv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// One finished document: what the block reports at its zero byte.
	typedef struct {
		logic [3:0]  status;
		logic [31:0] error_position;
		logic [31:0] entry_count;
	} verdict_t;

	logic clk;
	logic arst_n;

	jsv_in_if  in_ch();
	jsv_out_if out_ch();

	json_syntax_validator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (in_ch),
		.result_out(out_ch)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// Byte stream waiting to be offered, expected verdicts, test status.
	logic [7:0] byte_q[$];
	logic [7:0] doc[$];
	verdict_t   verdict_q[$];
	int         errors;
	logic       in_taken;
	logic       out_taken;
	logic       quiet;
	int         quiet_cnt;

	// ------------------------------------------------------------------
	// Predictor state: a shadow of the parser, updated per accepted byte.
	// ------------------------------------------------------------------
	logic [4:0]  mode;
	logic        nest_arr[64];
	int          depth;
	logic [31:0] pos;
	logic [31:0] entries;
	logic [31:0] tok;
	logic [31:0] mark;
	logic [15:0] acc;
	int          dl;
	logic [3:0]  err;
	logic [31:0] err_pos;
	logic [4:0]  ret_mode;
	logic        is_key;
	logic [1:0]  hk;
	string       lit_word[6] = '{"true", "false", "null", "NaN", "Infinity", "-Infinity"};

	function automatic logic ws_byte(logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	function automatic logic dec_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic hex_digit(logic [7:0] b);
		return dec_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic logic [3:0] nibble(logic [7:0] b);
		logic [7:0] v;
		if (dec_digit(b))
			v = b - 8'h30;
		else if (b >= "a" && b <= "f")
			v = b - "a" + 8'd10;
		else
			v = b - "A" + 8'd10;
		return v[3:0];
	endfunction

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void clear_parser();
		mode = M_VALUE; depth = 0; pos = '0; entries = '0; tok = '0; mark = '0;
		acc = '0; dl = 0; err = ST_OK; err_pos = '0; ret_mode = M_VALUE;
		is_key = 1'b0; hk = HK_X;
		foreach (nest_arr[i]) nest_arr[i] = 1'b0;
	endfunction

	function automatic void flag(logic [3:0] code, logic [31:0] where);
		err = code; err_pos = where; mode = M_ERR;
	endfunction

	function automatic void value_done();
		mode = (depth == 0) ? M_END : M_SEP;
	endfunction

	function automatic void close_level();
		if (depth > 0) depth--;
		value_done();
	endfunction

	function automatic void open_level(logic arr, logic [31:0] p);
		if (depth >= 64) begin
			flag(ST_TOO_DEEP, p);
		end else begin
			nest_arr[depth] = arr;
			depth++;
			entries = sat_inc(entries);
			mode = arr ? M_ARR_FIRST : M_OBJ_FIRST;
		end
	endfunction

	function automatic void begin_word(int id, int next);
		acc = id[15:0]; dl = next; mode = M_LIT;
	endfunction

	function automatic void begin_escape(logic [1:0] kind, int n, logic [31:0] p);
		hk = kind; dl = n; acc = '0; mark = sat_inc(p); mode = M_HEX;
	endfunction

	function automatic void number_done();
		entries = sat_inc(entries);
		value_done();
	endfunction

	// Advance the shadow parser by one byte; returns 1 to handle it again.
	function automatic bit parse_byte(logic [7:0] b);
		logic [31:0] p;
		logic [4:0]  m;
		logic        arr;
		int          id;
		int          i;
		logic [7:0]  lead;
		int          need;
		logic        bad;
		p = pos;
		m = mode;
		if (m <= M_END) begin
			if (ws_byte(b)) return 0;
			if (b == "/") begin
				ret_mode = m; mark = p; mode = M_SLASH;
				return 0;
			end
		end
		case (m)
			M_VALUE: begin
				tok = p;
				if (b == "{") open_level(1'b0, p);
				else if (b == "[") open_level(1'b1, p);
				else if (b == "\"") begin is_key = 1'b0; mode = M_STR; end
				else if (b == "t") begin_word(0, 1);
				else if (b == "f") begin_word(1, 1);
				else if (b == "n") begin_word(2, 1);
				else if (b == "N") begin_word(3, 1);
				else if (b == "I") begin_word(4, 1);
				else if (b == "-") mode = M_N_SIGN;
				else if (b == "0") mode = M_N_ZERO;
				else if (dec_digit(b)) mode = M_N_INT;
				else flag(ST_NO_VALUE, p);
			end
			M_OBJ_FIRST: begin
				if (b == "}") close_level();
				else if (b == "\"") begin tok = p; is_key = 1'b1; mode = M_STR; end
				else flag(ST_NO_KEY, p);
			end
			M_ARR_FIRST: begin
				if (b == "]") close_level();
				else begin
					mode = M_VALUE;
					return 1;
				end
			end
			M_COLON: begin
				if (b == ":") mode = M_VALUE; else flag(ST_NO_COLON, p);
			end
			M_SEP: begin
				arr = (depth > 0) ? nest_arr[depth - 1] : 1'b0;
				if (b == (arr ? "]" : "}")) close_level();
				else if (b == ",") mode = arr ? M_ARR_FIRST : M_OBJ_FIRST;
				else flag(ST_NO_COMMA, p);
			end
			M_END: if (b != 8'h00) flag(ST_TRAILING, p);
			M_SLASH: begin
				if (b == "/") mode = M_LINE;
				else if (b == "*") begin mark = sat_inc(p); mode = M_BLOCK; end
				else flag(ST_BAD_SLASH, mark);
			end
			M_LINE: begin
				if (b == 8'h0A) mode = ret_mode;
				else if (b == 8'h00) begin
					mode = ret_mode;
					return 1;
				end
			end
			M_BLOCK, M_BLOCK_STAR: begin
				if (b == 8'h00) flag(ST_OPEN_CMT, mark);
				else if (m == M_BLOCK_STAR && b == "/") mode = ret_mode;
				else mode = (b == "*") ? M_BLOCK_STAR : M_BLOCK;
			end
			M_LIT: begin
				id = (acc < 16'd6) ? int'(acc) : 0;
				i = (dl < 10) ? dl : 9;
				if (b != ((i < lit_word[id].len()) ? lit_word[id][i] : 8'h00)) begin
					flag(ST_NO_VALUE, tok);
				end else begin
					dl = i + 1;
					if (dl >= lit_word[id].len()) value_done();
				end
			end
			M_N_SIGN: begin
				if (b == "0") mode = M_N_ZERO;
				else if (dec_digit(b)) mode = M_N_INT;
				else if (b == "I") begin_word(5, 2);
				else flag(ST_NO_VALUE, tok);
			end
			M_N_ZERO: begin
				if (b == "x") mode = M_N_HEX0;
				else if (b == "b") mode = M_N_BIN0;
				else if (b == ".") mode = M_N_FRAC0;
				else if (b == "e" || b == "E") mode = M_N_EXP0;
				else if (b == 8'h00 || ws_byte(b) || b == "," || b == "}" || b == "]") begin
					number_done();
					return 1;
				end else flag(ST_NO_VALUE, tok);
			end
			M_N_HEX0, M_N_HEX: begin
				if (hex_digit(b)) mode = M_N_HEX;
				else if (m == M_N_HEX) begin
					number_done();
					return 1;
				end else flag(ST_NO_VALUE, tok);
			end
			M_N_BIN0, M_N_BIN: begin
				if (b == "0" || b == "1") mode = M_N_BIN;
				else if (m == M_N_BIN) begin
					number_done();
					return 1;
				end else flag(ST_NO_VALUE, tok);
			end
			M_N_INT, M_N_FRAC: begin
				if (dec_digit(b)) return 0;
				if (b == "." && m == M_N_INT) mode = M_N_FRAC0;
				else if (b == "e" || b == "E") mode = M_N_EXP0;
				else begin
					number_done();
					return 1;
				end
			end
			M_N_FRAC0: if (dec_digit(b)) mode = M_N_FRAC; else flag(ST_NO_VALUE, tok);
			M_N_EXP0: begin
				if (b == "+" || b == "-") mode = M_N_EXPS;
				else if (dec_digit(b)) mode = M_N_EXP;
				else flag(ST_NO_VALUE, tok);
			end
			M_N_EXPS: if (dec_digit(b)) mode = M_N_EXP; else flag(ST_NO_VALUE, tok);
			M_N_EXP: begin
				if (!dec_digit(b)) begin
					number_done();
					return 1;
				end
			end
			M_STR: begin
				if (b < 8'h20) flag(ST_OPEN_STR, tok);
				else if (b == "\"") begin
					entries = sat_inc(entries);
					if (is_key) mode = M_COLON; else value_done();
				end else if (b == "\\") mode = M_ESC;
				else if (b < 8'h80) begin
				end else if (b[7:5] == 3'b110 && b >= 8'hC2) begin
					acc = {8'h00, b}; dl = 1; mark = p; mode = M_UTF;
				end else if (b[7:4] == 4'hE) begin
					acc = {8'h00, b}; dl = 2; mark = p; mode = M_UTF;
				end else if (b[7:3] == 5'b11110 && b <= 8'hF4) begin
					acc = {8'h00, b}; dl = 3; mark = p; mode = M_UTF;
				end else flag(ST_BAD_UTF8, p);
			end
			M_ESC: begin
				if (b == 8'h00) flag(ST_OPEN_STR, tok);
				else if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
						b == "n" || b == "r" || b == "t") mode = M_STR;
				else if (b == "x") begin_escape(HK_X, 2, p);
				else if (b == "u") begin_escape(HK_U, 4, p);
				else if (b == "U") begin_escape(HK_BIGU, 8, p);
				else flag(ST_BAD_ESC, sat_inc(p));
			end
			M_HEX: begin
				if (!hex_digit(b)) begin
					flag((hk == HK_X) ? ST_BAD_X : (hk == HK_BIGU) ? ST_BAD_BIGU : ST_BAD_U,
						mark);
				end else begin
					acc = {acc[11:0], nibble(b)};
					if (dl > 0) dl--;
					if (dl == 0) begin
						if (hk == HK_U && acc >= 16'hD800 && acc <= 16'hDBFF) begin
							mark = sat_inc(p); mode = M_SUR_BS;
						end else if (hk == HK_LOW && (acc < 16'hDC00 || acc > 16'hDFFF))
							flag(ST_BAD_U, mark);
						else mode = M_STR;
					end
				end
			end
			M_SUR_BS: if (b == "\\") mode = M_SUR_U; else flag(ST_BAD_U, mark);
			M_SUR_U: if (b == "u") begin_escape(HK_LOW, 4, p); else flag(ST_BAD_U, mark);
			M_UTF: begin
				lead = acc[7:0];
				need = (lead[7:4] == 4'hE) ? 2 : (lead[7:3] == 5'b11110) ? 3 : 1;
				bad = b[7:6] != 2'b10;
				if (dl == need)
					bad = bad || (lead == 8'hE0 && b < 8'hA0) || (lead == 8'hED && b >= 8'hA0) ||
						(lead == 8'hF0 && b < 8'h90) || (lead == 8'hF4 && b > 8'h8F);
				if (bad) flag(ST_BAD_UTF8, mark);
				else begin
					if (dl > 0) dl--;
					if (dl == 0) mode = M_STR;
				end
			end
			default: ;
		endcase
		return 0;
	endfunction

	// Feed one accepted byte to the shadow parser; a zero byte yields a verdict.
	task automatic predict_byte(logic [7:0] b);
		verdict_t v;
		while (parse_byte(b)) ;
		if (b == 8'h00) begin
			v.status = err;
			v.error_position = (err != ST_OK) ? err_pos : 32'd0;
			v.entry_count = entries;
			verdict_q.push_back(v);
			clear_parser();
		end else begin
			pos = sat_inc(pos);
		end
	endtask

	// ------------------------------------------------------------------
	// Document builder
	// ------------------------------------------------------------------
	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
	endtask

	// Close the document with its zero byte and queue it for the driver.
	task automatic ship_doc();
		foreach (doc[i]) byte_q.push_back(doc[i]);
		byte_q.push_back(8'h00);
		doc.delete();
	endtask

	task automatic add_gap();
		case ($urandom_range(0, 9))
			0: add_text(" ");
			1: add_text("\t");
			2: add_text("\n");
			3: add_text("\r");
			4: add_text("/* c*/");
			5: add_text("//x\n");
			default: ;
		endcase
	endtask

	task automatic add_string();
		int n;
		add_text("\"");
		n = $urandom_range(0, 5);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: add_text("\\n");
				1: add_text("\\x4F");
				2: add_text("\\u00e9");
				3: add_text("\\ud83d\\ude00");
				4: add_text("\\U0001F600");
				5: begin
					doc.push_back(8'hC3); doc.push_back(8'hA9);
				end
				6: begin
					doc.push_back(8'hE2); doc.push_back(8'h82); doc.push_back(8'hAC);
				end
				7: begin
					doc.push_back(8'hF0); doc.push_back(8'h9F);
					doc.push_back(8'h98); doc.push_back(8'h80);
				end
				default: doc.push_back(8'($urandom_range(8'h20, 8'h7E)));
			endcase
			if (doc[$] == "\\" || doc[$] == "\"") void'(doc.pop_back());
		end
		add_text("\"");
	endtask

	task automatic add_number();
		if ($urandom_range(0, 3) == 0) add_text("-");
		case ($urandom_range(0, 5))
			0: add_text("0");
			1: add_text($sformatf("0x%0h", $urandom_range(0, 65535)));
			2: add_text($sformatf("0b%0b", $urandom_range(0, 31)));
			3: add_text($sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99)));
			4: add_text($sformatf("%0de%s%0d", $urandom_range(1, 99),
				$urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 20)));
			default: add_text($sformatf("%0d", $urandom_range(1, 100000)));
		endcase
	endtask

	task automatic add_value(int lvl);
		int n;
		case ($urandom_range(0, 9))
			0, 1: begin
				if (lvl < 4) begin
					n = $urandom_range(0, 3);
					add_text("{"); add_gap();
					for (int i = 0; i < n; i++) begin
						add_string(); add_gap(); add_text(":"); add_gap();
						add_value(lvl + 1); add_gap();
						if (i < n - 1 || $urandom_range(0, 3) == 0) begin
							add_text(","); add_gap();
						end
					end
					add_text("}");
				end else add_text("null");
			end
			2, 3: begin
				if (lvl < 4) begin
					n = $urandom_range(0, 4);
					add_text("["); add_gap();
					for (int i = 0; i < n; i++) begin
						add_value(lvl + 1); add_gap();
						if (i < n - 1 || $urandom_range(0, 3) == 0) begin
							add_text(","); add_gap();
						end
					end
					add_text("]");
				end else add_text("1");
			end
			4, 5: add_string();
			6, 7: add_number();
			default: add_text(lit_word[$urandom_range(0, 5)]);
		endcase
	endtask

	// Well-formed document, sometimes damaged, sometimes pure noise.
	task automatic add_random_doc();
		int k;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) doc.push_back(8'($urandom_range(1, 255)));
		end else begin
			add_gap(); add_value(0); add_gap();
			if (doc.size() > 0 && $urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, doc.size() - 1);
				case ($urandom_range(0, 2))
					0: doc[k] = 8'($urandom_range(1, 255));
					1: doc.insert(k, 8'($urandom_range(1, 255)));
					default: while (doc.size() > k) void'(doc.pop_back());
				endcase
			end
		end
		ship_doc();
	endtask

	task automatic add_directed();
		string cases[$];
		cases = '{"{}", "[1, 2,]", "{\"a\": [true, false, null],}", "0x1Fab", "-0b101",
			"[NaN, Infinity, -Infinity, 0.5e+3, 2E-7, -0, 1e5]",
			"\"\\x41\\u00e9\\ud83d\\ude00\\U0001F600\\\"\\/\\b\\f\\r\\t\"",
			"/*c*/ // line\n 1 /**/", "/* open", "/x", "\"abc", "\"\\xZ1\"", "\"\\u12G4\"",
			"\"\\U0001Z\"", "\"\\q\"", "{1}", "{\"a\" 1}", "[1 2]", "]", "1 2", "01",
			"tru", "\"\\ud800x\"", "\"\\ud800\\n\"", "\"\\ud800\\u0041\"", "// to end",
			"\"\\", "-x", "0x", "0b2", "1.", "1e", "1e+"};
		foreach (cases[i]) begin
			add_text(cases[i]);
			ship_doc();
		end
		// UTF-8 boundaries: overlong and invalid leads, range checks on the second byte
		doc = '{8'h22, 8'hC0, 8'h80, 8'h22}; ship_doc();
		doc = '{8'h22, 8'hE0, 8'h80, 8'h80, 8'h22}; ship_doc();
		doc = '{8'h22, 8'hED, 8'hA0, 8'h80, 8'h22}; ship_doc();
		doc = '{8'h22, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h22}; ship_doc();
		doc = '{8'h22, 8'hF0, 8'h8F, 8'h80, 8'h80, 8'h22}; ship_doc();
		doc = '{8'h22, 8'hF5, 8'h22}; ship_doc();
		doc = '{8'h22, 8'hFF, 8'h01}; ship_doc();
		// Nesting: exactly at the limit, then one level past it
		repeat (64) add_text("[");
		repeat (64) add_text("]");
		ship_doc();
		repeat (65) add_text("[");
		ship_doc();
	endtask

	// ------------------------------------------------------------------
	// Driver: offer bytes at the falling edge, with random gaps.
	// ------------------------------------------------------------------
	int tx_gap;

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	always @(negedge clk) begin
		logic       nxt_valid;
		logic [7:0] nxt_byte;
		nxt_valid = in_ch.valid;
		nxt_byte = in_ch.text_byte;
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (quiet_cnt == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
				quiet_cnt = 64;
			end
			if (tx_gap > 0) begin
				tx_gap--;
				nxt_valid = 1'b0;
			end else if (byte_q.size() > 0) begin
				nxt_valid = 1'b1;
				nxt_byte = byte_q.pop_front();
				tx_gap = draw_wait();
				quiet_cnt--;
			end else begin
				nxt_valid = 1'b0;
			end
		end
		in_ch.valid <= nxt_valid;
		in_ch.text_byte <= nxt_byte;
	end

	// Receiver: random stall per result, plus one long hold-off to back up the block.
	int rx_wait;
	int long_hold;
	int results_seen;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				results_seen++;
				rx_wait = draw_wait();
				if (results_seen == 12) long_hold = 400;
			end
			if (long_hold > 0) begin
				long_hold--;
				out_ch.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each input transaction, check each output one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		verdict_t want;
		in_taken <= in_ch.valid && in_ch.ready;
		out_taken <= out_ch.valid && out_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) predict_byte(in_ch.text_byte);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result, got status=%0d pos=%0d count=%0d", $realtime,
					out_ch.status, out_ch.error_position, out_ch.entry_count);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (out_ch.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $realtime, want.status,
						out_ch.status);
					errors++;
				end
				if (out_ch.error_position !== want.error_position) begin
					$display("%0t: error_position expected %0d got %0d", $realtime,
						want.error_position, out_ch.error_position);
					errors++;
				end
				if (out_ch.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d got %0d", $realtime,
						want.entry_count, out_ch.entry_count);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	int idle_cycles;

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of test
	// ------------------------------------------------------------------
	initial begin
		int docs;
		errors = 0; tx_gap = 0; rx_wait = 0; long_hold = 0; results_seen = 0;
		quiet = 1'b0; quiet_cnt = 0; idle_cycles = 0;
		in_taken = 1'b0; out_taken = 1'b0;
		in_ch.valid = 1'b0; in_ch.text_byte = 8'h00; out_ch.ready = 1'b0;
		clear_parser();
		arst_n = 1'b0;
		add_directed();
		docs = 0;
		while (byte_q.size() < 1300 || docs < 60) begin
			add_random_doc();
			docs++;
		end
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// Drain: all bytes sent, no verdict outstanding.
		do @(posedge clk);
		while (byte_q.size() > 0 || in_ch.valid || verdict_q.size() > 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
